@@ design/mcoc_pkg.sv @@
// ---------------------------------------------------------------------------
// mcoc_pkg
// Shared types and constants for the matrix-chain order cost block.
// ---------------------------------------------------------------------------
package mcoc_pkg;

  localparam int DEF_MAX_MATRICES = 8;
  localparam int DEF_DIM_BITS     = 16;

  localparam int DIM_IN_W = 16;  // width of the dimension port
  localparam int CFG_W    = 4;   // matrix_count register
  localparam int CNT_W    = 4;   // counts 0..8
  localparam int IDX_W    = 3;   // zero-based matrix index 0..7
  localparam int POS_W    = 4;   // one-based row/col on the result port
  localparam int COST_W   = 51;
  localparam int SPLIT_W  = 3;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAIR,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } mcoc_state_t;

  typedef struct packed {
    logic             dims_we;
    logic [CNT_W-1:0] dims_addr;
    logic             issue;      // one split evaluation enters the pipe
    logic             last;       // final split of the current pair
    idx_t             i0;
    idx_t             j0;
    idx_t             v0;
    logic             emit_rd;    // table read for the result stream
    idx_t             emit_row;
    idx_t             emit_col;
    logic             emit_last;
    logic             out_load;   // move read data into the output register
  } mcoc_cmd_t;

  typedef struct packed {
    logic pair_done;
    logic out_free;
  } mcoc_status_t;

endpackage

@@ design/matrix_chain_order_cost.sv @@
// Compute: after the beat carrying the last dimension, each pair (i,j) runs its
//   splits through the shared split evaluation pipe, and the next pair starts
//   only once the result of the pair has been written to the table.
// Readout: one table entry per cycle while out_ready is high, n*n beats.
// Load beats are taken in the load state; compute and readout close the input.
// Reset: synchronous active low; matrix_count returns to 4, load restarts.
// ---------------------------------------------------------------------------
// matrix_chain_order_cost
// Matrix-chain multiplication order: loads n+1 dimensions, fills the least
// cost and split tables by increasing span, streams both tables row by row.
// ---------------------------------------------------------------------------
module matrix_chain_order_cost #(
  parameter int MAX_MATRICES = mcoc_pkg::DEF_MAX_MATRICES,
  parameter int DIM_BITS     = mcoc_pkg::DEF_DIM_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [mcoc_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcoc_pkg::DIM_IN_W-1:0] in_dimension,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mcoc_pkg::POS_W-1:0]    out_row_index,
  output logic [mcoc_pkg::POS_W-1:0]    out_col_index,
  output logic [mcoc_pkg::COST_W-1:0]   out_min_cost,
  output logic [mcoc_pkg::SPLIT_W-1:0]  out_best_split,
  output logic                          out_last_entry
);

  mcoc_pkg::mcoc_cmd_t    cmd;
  mcoc_pkg::mcoc_status_t status;

  mcoc_ctrl #(
    .MAX_MATRICES (MAX_MATRICES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .status      (status),
    .cmd         (cmd)
  );

  mcoc_dp #(
    .MAX_MATRICES (MAX_MATRICES),
    .DIM_BITS     (DIM_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_dimension   (in_dimension),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_row_index  (out_row_index),
    .out_col_index  (out_col_index),
    .out_min_cost   (out_min_cost),
    .out_best_split (out_best_split),
    .out_last_entry (out_last_entry)
  );

  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !(cmd.issue || cmd.emit_rd || cmd.out_load))
    else $error("load beat taken while compute or readout active");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten before handoff");

  a_write_drained: assert property (@(posedge clk) disable iff (!rst_n)
    status.pair_done |-> !cmd.issue)
    else $error("split issued while pair result still being written");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.emit_last && !cmd.emit_rd) |=> in_ready)
    else $error("input not reopened after final table entry");

endmodule

@@ design/mcoc_ctrl.sv @@
// ---------------------------------------------------------------------------
// mcoc_ctrl
// Sequencer: dimension load, span/pair/split loops of the program, and the
// row-by-row table readout.
// ---------------------------------------------------------------------------
module mcoc_ctrl #(
  parameter int MAX_MATRICES = mcoc_pkg::DEF_MAX_MATRICES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [mcoc_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mcoc_pkg::mcoc_status_t     status,
  output mcoc_pkg::mcoc_cmd_t        cmd
);

  mcoc_pkg::mcoc_state_t state_r, state_nxt;

  logic [mcoc_pkg::CFG_W-1:0] mc_r;
  logic [mcoc_pkg::CNT_W-1:0] load_cnt_r, load_cnt_nxt;
  logic [mcoc_pkg::CNT_W-1:0] n_eff;
  mcoc_pkg::idx_t             n_m1;
  mcoc_pkg::idx_t             span_r, span_nxt;
  mcoc_pkg::idx_t             i0_r, i0_nxt;
  mcoc_pkg::idx_t             v0_r, v0_nxt;
  mcoc_pkg::idx_t             r0_r, r0_nxt;
  mcoc_pkg::idx_t             c0_r, c0_nxt;
  mcoc_pkg::idx_t             j0;
  logic                       accept;
  logic                       load_done;
  logic                       v_last;
  logic                       pair_more;
  logic                       run_done;
  logic                       emit_end;

  // count of zero acts as one, anything above the build limit is clamped
  always_comb begin
    priority if (mc_r == '0) begin
      n_eff = mcoc_pkg::CNT_W'(1);
    end else if (mc_r > mcoc_pkg::CNT_W'(MAX_MATRICES)) begin
      n_eff = mcoc_pkg::CNT_W'(MAX_MATRICES);
    end else begin
      n_eff = mc_r;
    end
  end

  assign n_m1      = mcoc_pkg::idx_t'(n_eff - mcoc_pkg::CNT_W'(1));
  assign j0        = i0_r + span_r;
  assign accept    = in_valid && in_ready;
  assign load_done = accept && (load_cnt_r == n_eff);
  assign v_last    = (mcoc_pkg::idx_t'(v0_r + mcoc_pkg::idx_t'(1)) == j0);
  assign pair_more = (j0 != n_m1);
  assign run_done  = (span_r == n_m1);
  assign emit_end  = (r0_r == n_m1) && (c0_r == n_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mcoc_pkg::ST_LOAD;
      mc_r       <= mcoc_pkg::CFG_W'(4);
      load_cnt_r <= '0;
      span_r     <= '0;
      i0_r       <= '0;
      v0_r       <= '0;
      r0_r       <= '0;
      c0_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      span_r     <= span_nxt;
      i0_r       <= i0_nxt;
      v0_r       <= v0_nxt;
      r0_r       <= r0_nxt;
      c0_r       <= c0_nxt;
      if (cfg_wr_en) begin
        mc_r <= cfg_wr_data;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcoc_pkg::ST_LOAD: begin
        if (load_done) begin
          state_nxt = (n_eff == mcoc_pkg::CNT_W'(1)) ? mcoc_pkg::ST_EMIT_RD
                                                      : mcoc_pkg::ST_PAIR;
        end
      end
      mcoc_pkg::ST_PAIR: begin
        if (v_last) begin
          state_nxt = mcoc_pkg::ST_DRAIN;
        end
      end
      mcoc_pkg::ST_DRAIN: begin
        if (status.pair_done) begin
          state_nxt = run_done ? mcoc_pkg::ST_EMIT_RD : mcoc_pkg::ST_PAIR;
        end
      end
      mcoc_pkg::ST_EMIT_RD: begin
        state_nxt = mcoc_pkg::ST_EMIT_LD;
      end
      mcoc_pkg::ST_EMIT_LD: begin
        if (status.out_free && emit_end) begin
          state_nxt = mcoc_pkg::ST_LOAD;
        end
      end
      default: state_nxt = mcoc_pkg::ST_LOAD;
    endcase
  end

  // loop counters
  always_comb begin
    load_cnt_nxt = load_cnt_r;
    span_nxt     = span_r;
    i0_nxt       = i0_r;
    v0_nxt       = v0_r;
    r0_nxt       = r0_r;
    c0_nxt       = c0_r;
    if (cfg_wr_en) begin
      load_cnt_nxt = '0;
    end else if (accept) begin
      load_cnt_nxt = load_done ? '0 : load_cnt_r + mcoc_pkg::CNT_W'(1);
    end
    unique case (state_r)
      mcoc_pkg::ST_LOAD: begin
        if (load_done) begin
          span_nxt = mcoc_pkg::idx_t'(1);
          i0_nxt   = '0;
          v0_nxt   = '0;
          r0_nxt   = '0;
          c0_nxt   = '0;
        end
      end
      mcoc_pkg::ST_PAIR: begin
        if (!v_last) begin
          v0_nxt = v0_r + mcoc_pkg::idx_t'(1);
        end
      end
      mcoc_pkg::ST_DRAIN: begin
        if (status.pair_done && !run_done) begin
          if (pair_more) begin
            i0_nxt = i0_r + mcoc_pkg::idx_t'(1);
            v0_nxt = i0_r + mcoc_pkg::idx_t'(1);
          end else begin
            span_nxt = span_r + mcoc_pkg::idx_t'(1);
            i0_nxt   = '0;
            v0_nxt   = '0;
          end
        end
      end
      mcoc_pkg::ST_EMIT_RD: begin
      end
      mcoc_pkg::ST_EMIT_LD: begin
        if (status.out_free && !emit_end) begin
          if (c0_r == n_m1) begin
            c0_nxt = '0;
            r0_nxt = r0_r + mcoc_pkg::idx_t'(1);
          end else begin
            c0_nxt = c0_r + mcoc_pkg::idx_t'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.dims_addr = load_cnt_r;
    cmd.i0        = i0_r;
    cmd.j0        = j0;
    cmd.v0        = v0_r;
    cmd.last      = v_last;
    cmd.emit_row  = r0_r;
    cmd.emit_col  = c0_r;
    cmd.emit_last = emit_end;
    unique case (state_r)
      mcoc_pkg::ST_LOAD: begin
        in_ready    = 1'b1;
        cmd.dims_we = in_valid;
      end
      mcoc_pkg::ST_PAIR: begin
        cmd.issue = 1'b1;
      end
      mcoc_pkg::ST_DRAIN: begin
      end
      mcoc_pkg::ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
      end
      mcoc_pkg::ST_EMIT_LD: begin
        if (status.out_free) begin
          // hand off the held entry and fetch the next one in the same cycle
          cmd.out_load  = 1'b1;
          cmd.emit_rd   = !emit_end;
          cmd.emit_row  = r0_nxt;
          cmd.emit_col  = c0_nxt;
          cmd.emit_last = (r0_nxt == n_m1) && (c0_nxt == n_m1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/mcoc_dp.sv @@
// ---------------------------------------------------------------------------
// mcoc_dp
// Datapath: dimension stores, cost/split table, split evaluation pipe with
// running minimum, and the result output register.
// ---------------------------------------------------------------------------
module mcoc_dp #(
  parameter int MAX_MATRICES = mcoc_pkg::DEF_MAX_MATRICES,
  parameter int DIM_BITS     = mcoc_pkg::DEF_DIM_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mcoc_pkg::mcoc_cmd_t           cmd,
  output mcoc_pkg::mcoc_status_t        status,
  input  logic [mcoc_pkg::DIM_IN_W-1:0] in_dimension,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [mcoc_pkg::POS_W-1:0]    out_row_index,
  output logic [mcoc_pkg::POS_W-1:0]    out_col_index,
  output logic [mcoc_pkg::COST_W-1:0]   out_min_cost,
  output logic [mcoc_pkg::SPLIT_W-1:0]  out_best_split,
  output logic                          out_last_entry
);

  localparam int DEPTH   = MAX_MATRICES * MAX_MATRICES;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DDEPTH  = MAX_MATRICES + 1;
  localparam int DADDR_W = $clog2(DDEPTH);
  localparam int P1_W    = 2 * DIM_BITS;
  localparam int P2_W    = 3 * DIM_BITS;
  localparam int COST_W  = mcoc_pkg::COST_W;
  localparam int SPLIT_W = mcoc_pkg::SPLIT_W;
  localparam int ENTRY_W = SPLIT_W + COST_W;

  function automatic logic [ADDR_W-1:0] tab_addr(mcoc_pkg::idx_t row,
                                                 mcoc_pkg::idx_t col);
    return ADDR_W'(row) * ADDR_W'(MAX_MATRICES) + ADDR_W'(col);
  endfunction

  // three copies of the dimension store, one per operand read port
  logic [DIM_BITS-1:0] dim_mem_a [DDEPTH];
  logic [DIM_BITS-1:0] dim_mem_v [DDEPTH];
  logic [DIM_BITS-1:0] dim_mem_j [DDEPTH];
  logic [ENTRY_W-1:0]  tab_mem   [DEPTH];

  logic [mcoc_pkg::CNT_W-1:0] v_dim_addr;
  logic [mcoc_pkg::CNT_W-1:0] j_dim_addr;
  logic [ADDR_W-1:0]          rd_addr_a;
  logic [ADDR_W-1:0]          rd_addr_b;
  logic [ADDR_W-1:0]          wr_addr;
  logic                       tab_we;
  logic [ENTRY_W-1:0]         tab_wdata;

  logic [DIM_BITS-1:0] da_r, dv_r, dj_r;
  logic [ENTRY_W-1:0]  rda_r, rdb_r;

  // stage 1: read data
  logic               s1_vld_r, s1_last_r, s1_first_r, s1_zb_r;
  logic [SPLIT_W-1:0] s1_v_r;
  // stage 2: first product, partial sum
  logic               s2_vld_r, s2_last_r, s2_first_r;
  logic [SPLIT_W-1:0] s2_v_r;
  logic [P1_W-1:0]    p1_r;
  logic [DIM_BITS-1:0] dj2_r;
  logic [COST_W-1:0]  sum2_r;
  // stage 3: full product, compare
  logic               s3_vld_r, s3_last_r, s3_first_r;
  logic [SPLIT_W-1:0] s3_v_r;
  logic [P2_W-1:0]    p2_r;
  logic [COST_W-1:0]  sum3_r;

  logic [COST_W-1:0]  best_r;
  logic [SPLIT_W-1:0] best_split_r;
  logic [COST_W-1:0]  total;
  logic               take;
  logic [COST_W-1:0]  sel_cost;
  logic [SPLIT_W-1:0] sel_split;
  logic               pair_done_r;

  mcoc_pkg::idx_t e_row_r, e_col_r;
  logic           e_last_r;
  logic           out_valid_r;
  logic [mcoc_pkg::POS_W-1:0] out_row_r, out_col_r;
  logic [COST_W-1:0]          out_cost_r;
  logic [SPLIT_W-1:0]         out_split_r;
  logic                       out_last_r;

  assign v_dim_addr = mcoc_pkg::CNT_W'(cmd.v0) + mcoc_pkg::CNT_W'(1);
  assign j_dim_addr = mcoc_pkg::CNT_W'(cmd.j0) + mcoc_pkg::CNT_W'(1);
  assign rd_addr_a  = cmd.issue ? tab_addr(cmd.i0, cmd.v0)
                                : tab_addr(cmd.emit_row, cmd.emit_col);
  assign rd_addr_b  = tab_addr(cmd.v0 + mcoc_pkg::idx_t'(1), cmd.j0);
  assign wr_addr    = tab_addr(cmd.i0, cmd.j0);

  always_ff @(posedge clk) begin
    if (cmd.dims_we) begin
      dim_mem_a[cmd.dims_addr[DADDR_W-1:0]] <= in_dimension[DIM_BITS-1:0];
      dim_mem_v[cmd.dims_addr[DADDR_W-1:0]] <= in_dimension[DIM_BITS-1:0];
      dim_mem_j[cmd.dims_addr[DADDR_W-1:0]] <= in_dimension[DIM_BITS-1:0];
    end
    if (cmd.issue) begin
      da_r  <= dim_mem_a[DADDR_W'(cmd.i0)];
      dv_r  <= dim_mem_v[v_dim_addr[DADDR_W-1:0]];
      dj_r  <= dim_mem_j[j_dim_addr[DADDR_W-1:0]];
      rdb_r <= tab_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[wr_addr] <= tab_wdata;
    end
    if (cmd.issue || cmd.emit_rd) begin
      rda_r <= tab_mem[rd_addr_a];
    end
  end

  // diagonal entries are never written; their cost is taken as zero
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_last_r  <= cmd.last;
      s1_first_r <= (cmd.v0 == cmd.i0);
      s1_zb_r    <= (mcoc_pkg::idx_t'(cmd.v0 + mcoc_pkg::idx_t'(1)) == cmd.j0);
      s1_v_r     <= SPLIT_W'(cmd.v0) + SPLIT_W'(1);
    end
    p1_r       <= P1_W'(da_r) * P1_W'(dv_r);
    dj2_r      <= dj_r;
    sum2_r     <= (s1_first_r ? '0 : rda_r[COST_W-1:0])
                + (s1_zb_r ? '0 : rdb_r[COST_W-1:0]);
    s2_last_r  <= s1_last_r;
    s2_first_r <= s1_first_r;
    s2_v_r     <= s1_v_r;
    p2_r       <= P2_W'(p1_r) * P2_W'(dj2_r);
    sum3_r     <= sum2_r;
    s3_last_r  <= s2_last_r;
    s3_first_r <= s2_first_r;
    s3_v_r     <= s2_v_r;
    if (s3_vld_r) begin
      best_r       <= sel_cost;
      best_split_r <= sel_split;
    end
  end

  // later split wins a tie
  assign total     = sum3_r + COST_W'(p2_r);
  assign take      = s3_first_r || (total <= best_r);
  assign sel_cost  = take ? total : best_r;
  assign sel_split = take ? s3_v_r : best_split_r;
  assign tab_we    = s3_vld_r && s3_last_r;
  assign tab_wdata = {sel_split, sel_cost};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      pair_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= cmd.issue;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      pair_done_r <= tab_we;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_rd) begin
      e_row_r  <= cmd.emit_row;
      e_col_r  <= cmd.emit_col;
      e_last_r <= cmd.emit_last;
    end
    if (cmd.out_load) begin
      out_row_r   <= mcoc_pkg::POS_W'(e_row_r) + mcoc_pkg::POS_W'(1);
      out_col_r   <= mcoc_pkg::POS_W'(e_col_r) + mcoc_pkg::POS_W'(1);
      out_cost_r  <= (e_row_r < e_col_r) ? rda_r[COST_W-1:0] : '0;
      out_split_r <= (e_row_r < e_col_r) ? rda_r[ENTRY_W-1:COST_W] : '0;
      out_last_r  <= e_last_r;
    end
  end

  assign status.pair_done = pair_done_r;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_row_index  = out_row_r;
  assign out_col_index  = out_col_r;
  assign out_min_cost   = out_cost_r;
  assign out_best_split = out_split_r;
  assign out_last_entry = out_last_r;

endmodule

@@ dv/tb_matrix_chain_order_cost.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_matrix_chain_order_cost
// Loads dimension chains at several matrix counts, predicts the least-cost
// and split tables by the chain dynamic program, and checks every table
// entry streamed back against the prediction, with random gaps on both sides.
// ---------------------------------------------------------------------------
module tb_matrix_chain_order_cost;

  localparam int MAX_N    = mcoc_pkg::DEF_MAX_MATRICES;
  localparam int POS_W    = mcoc_pkg::POS_W;
  localparam int COST_W   = mcoc_pkg::COST_W;
  localparam int SPLIT_W  = mcoc_pkg::SPLIT_W;
  localparam int CFG_W    = mcoc_pkg::CFG_W;
  localparam int DIM_IN_W = mcoc_pkg::DIM_IN_W;
  localparam longint unsigned COST_MASK = 64'h0007_FFFF_FFFF_FFFF;
  // a load beat gives no result, so let any compute finish before a count write
  localparam int SETTLE_CYCLES = 260;
  localparam int GAP_PCT = 22;

  typedef struct packed {
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [COST_W-1:0]  cost;
    logic [SPLIT_W-1:0] split;
    logic               last;
  } table_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [DIM_IN_W-1:0] in_dimension = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [POS_W-1:0] out_row_index;
  logic [POS_W-1:0] out_col_index;
  logic [COST_W-1:0] out_min_cost;
  logic [SPLIT_W-1:0] out_best_split;
  logic out_last_entry;

  // predictor state
  logic [CFG_W-1:0] chain_len_reg = CFG_W'(4);
  int unsigned dims_loaded = 0;
  logic [DIM_IN_W-1:0] chain_dims [0:MAX_N];

  table_entry_t entries_due[$];
  logic [DIM_IN_W-1:0] dims_pending[$];
  int unsigned dims_queued = 0;
  int unsigned dims_accepted = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  matrix_chain_order_cost u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_dimension  (in_dimension),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_col_index (out_col_index),
    .out_min_cost  (out_min_cost),
    .out_best_split(out_best_split),
    .out_last_entry(out_last_entry)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // last quarter of each repeating cycle_count window runs with no gaps at all
  function automatic bit take_gap();
    if ((cycle_count % 2048) >= 1536) return 1'b0;
    return $urandom_range(0, 99) < GAP_PCT;
  endfunction

  function automatic int unsigned effective_len(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_N) return MAX_N;
    return int'(v);
  endfunction

  // fill cost/split tables by increasing span, queue n*n table entries
  function automatic void solve_chain(int unsigned n);
    logic [COST_W-1:0]  cost_tab  [0:MAX_N-1][0:MAX_N-1];
    logic [SPLIT_W-1:0] split_tab [0:MAX_N-1][0:MAX_N-1];
    longint unsigned trial;
    longint unsigned best;
    int unsigned best_v;
    int unsigned span;
    int unsigned i;
    int unsigned j;
    int unsigned v;
    table_entry_t e;
    for (i = 0; i < MAX_N; i++) begin
      for (j = 0; j < MAX_N; j++) begin
        cost_tab[i][j] = '0;
        split_tab[i][j] = '0;
      end
    end
    for (span = 1; span < n; span++) begin
      for (i = 1; i + span <= n; i++) begin
        j = i + span;
        best = 0;
        best_v = 0;
        for (v = i; v < j; v++) begin
          trial = longint'(cost_tab[i-1][v-1]) + longint'(cost_tab[v][j-1])
                + longint'(chain_dims[i-1]) * longint'(chain_dims[v])
                  * longint'(chain_dims[j]);
          trial = trial & COST_MASK;
          // later split wins a tie
          if (v == i || trial <= best) begin
            best = trial;
            best_v = v;
          end
        end
        cost_tab[i-1][j-1] = COST_W'(best);
        split_tab[i-1][j-1] = SPLIT_W'(best_v);
      end
    end
    for (i = 0; i < n; i++) begin
      for (j = 0; j < n; j++) begin
        e.row = POS_W'(i + 1);
        e.col = POS_W'(j + 1);
        e.cost = cost_tab[i][j];
        e.split = split_tab[i][j];
        e.last = (i == n - 1) && (j == n - 1);
        entries_due.push_back(e);
      end
    end
  endfunction

  function automatic void take_dimension(logic [DIM_IN_W-1:0] d);
    int unsigned n;
    n = effective_len(chain_len_reg);
    if (dims_loaded > n) dims_loaded = 0;
    chain_dims[dims_loaded] = d;
    dims_loaded++;
    if (dims_loaded == n + 1) begin
      dims_loaded = 0;
      solve_chain(n);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        take_dimension(in_dimension);
        dims_accepted <= dims_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (dims_pending.size() != 0 && !take_gap()) begin
          in_valid <= 1'b1;
          in_dimension <= dims_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // monitor
  always @(posedge clk) begin : result_check
    table_entry_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (entries_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual row %0d col %0d cost %0d",
                   $time, out_row_index, out_col_index, out_min_cost);
          error_count++;
        end else begin
          want = entries_due.pop_front();
          check_field("row_index", want.row, out_row_index);
          check_field("col_index", want.col, out_col_index);
          check_field("min_cost", want.cost, out_min_cost);
          check_field("best_split", want.split, out_best_split);
          check_field("last_entry", want.last, out_last_entry);
        end
      end
      out_ready <= !take_gap();
    end
  end

  task automatic write_chain_len(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chain_len_reg = v;
    dims_loaded = 0;
  endtask

  task automatic queue_dim(logic [DIM_IN_W-1:0] v);
    dims_pending.push_back(v);
    dims_queued++;
  endtask

  task automatic wait_drained();
    while (dims_accepted != dims_queued || entries_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly small values so that splits and ties vary
  function automatic logic [DIM_IN_W-1:0] random_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return DIM_IN_W'($urandom_range(0, 65535));
      4: return DIM_IN_W'(1) << $urandom_range(0, DIM_IN_W - 1);
      default: return DIM_IN_W'($urandom_range(1, 24));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned random_items;
    int unsigned n;
    int unsigned extra;
    logic [CFG_W-1:0] len_cfg;
    random_items = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset count of four, all dims at max: largest costs and ties throughout
    repeat (5) queue_dim('1);
    wait_drained();

    // zero count acts as a single matrix
    write_chain_len(CFG_W'(0));
    queue_dim('0);
    queue_dim('1);
    wait_drained();

    write_chain_len(CFG_W'(MAX_N));
    queue_dim(16'h8000);
    queue_dim(16'd3);
    queue_dim(16'h5555);
    queue_dim(16'hAAAA);
    queue_dim(16'd7);
    queue_dim(16'd1);
    queue_dim(16'd0);
    queue_dim(16'h7FFF);
    queue_dim(16'hFFFF);
    wait_drained();

    // count above the maximum, abandoned mid-load by a count write
    write_chain_len('1);
    queue_dim(16'd100);
    queue_dim(16'd200);
    queue_dim(16'd300);
    wait_drained();
    write_chain_len(CFG_W'(2));
    repeat (3) queue_dim(16'd10);
    wait_drained();

    while (random_items < 120) begin
      if ($urandom_range(0, 9) < 8) len_cfg = CFG_W'($urandom_range(1, MAX_N));
      else len_cfg = CFG_W'($urandom_range(0, 15));
      write_chain_len(len_cfg);
      n = effective_len(len_cfg);
      repeat ($urandom_range(1, 3)) begin
        repeat (n + 1) queue_dim(random_dim());
        random_items += n + 1;
      end
      if ($urandom_range(0, 4) == 0) begin
        extra = $urandom_range(1, n);
        repeat (extra) queue_dim(random_dim());
        random_items += extra;
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
